>>> hw/rtl/fmps_pkg.sv
`timescale 1ns / 1ps

package fmps_pkg;

	// Default number of synth channels.
	localparam int NUM_CHANNELS_DEF = 9;

	// Frequency window of one octave and the step that moves between octaves.
	localparam logic [9:0] FREQ_LOW  = 10'h156;
	localparam logic [9:0] FREQ_HIGH = 10'h2AE;
	localparam logic [9:0] FREQ_SPAN = FREQ_HIGH - FREQ_LOW;

	// Octave limits.
	localparam logic [2:0] OCT_MIN = 3'd0;
	localparam logic [2:0] OCT_MAX = 3'd7;

	// Key-on bit in the block/key register byte.
	localparam logic [7:0] KEY_ON_MASK = 8'h20;

	// Register kinds on the result channel.
	localparam logic REG_FREQ_LOW = 1'b0;
	localparam logic REG_BLOCK    = 1'b1;

	// Item operations.
	typedef enum logic [1:0] {
		OP_SET_NOTE   = 2'd0,
		OP_SET_TARGET = 2'd1,
		OP_PORTA      = 2'd2,
		OP_TONE       = 2'd3
	} opcode_t;

	// Stored state of one channel.
	typedef struct packed {
		logic [9:0] fnum;
		logic [2:0] octave;
		logic       key_on;
		logic [9:0] tfnum;
		logic [2:0] toctave;
		logic [6:0] speed;
		logic [7:0] dir;
	} chan_state_t;

	// Result of one item as seen by the output serializer.
	typedef struct packed {
		logic       emit;
		logic [7:0] freq_byte;
		logic [7:0] block_byte;
	} emit_t;

endpackage

>>> hw/rtl/fmps_chan_state.sv
`timescale 1ns / 1ps

module fmps_chan_state #(
	parameter int NUM_CHANNELS = fmps_pkg::NUM_CHANNELS_DEF,
	parameter int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_W-1:0]     idx,
	input  logic                 wr_en,
	input  fmps_pkg::chan_state_t wr_data,
	output fmps_pkg::chan_state_t rd_data
);
	import fmps_pkg::*;

	chan_state_t state_q [NUM_CHANNELS];

	// Read the addressed channel.
	assign rd_data = state_q[idx];

	// Per-channel state, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				state_q[i] <= '0;
			end
		end else if (wr_en) begin
			state_q[idx] <= wr_data;
		end
	end

endmodule

>>> hw/rtl/fmps_slide_core.sv
`timescale 1ns / 1ps

module fmps_slide_core (
	input  fmps_pkg::opcode_t     opcode,
	input  logic [9:0]            fnum_in,
	input  logic [2:0]            octave_in,
	input  logic                  key_on_in,
	input  logic [6:0]            slide_speed_in,
	input  logic signed [7:0]     step_amount,
	input  fmps_pkg::chan_state_t cur,
	output fmps_pkg::chan_state_t nxt,
	output fmps_pkg::emit_t       res
);
	import fmps_pkg::*;

	logic [7:0]         step_sel;
	logic signed [11:0] sum;
	logic signed [11:0] f_adj;
	logic [2:0]         o_adj;
	logic [12:0]        pitch_new;
	logic [12:0]        pitch_tgt;
	logic               reached;
	logic [6:0]         spd_new;
	logic [12:0]        pitch_cur;
	logic [12:0]        pitch_set;
	logic [7:0]         dir_new;

	// Signed step: stored direction for a tone slide, item step otherwise.
	assign step_sel = (opcode == OP_TONE) ? cur.dir : step_amount;
	assign sum = $signed({2'b00, cur.fnum}) + $signed({{4{step_sel[7]}}, step_sel});

	// Wrap into the neighboring octave, or clamp at the lowest and highest octave.
	always_comb begin
		f_adj = sum;
		o_adj = cur.octave;
		if (sum < $signed({2'b00, FREQ_LOW})) begin
			if (cur.octave != OCT_MIN) begin
				o_adj = cur.octave - 3'd1;
				f_adj = sum + $signed({2'b00, FREQ_SPAN});
			end else begin
				f_adj = $signed({2'b00, FREQ_LOW});
			end
		end else if (sum > $signed({2'b00, FREQ_HIGH})) begin
			if (cur.octave != OCT_MAX) begin
				o_adj = cur.octave + 3'd1;
				f_adj = sum - $signed({2'b00, FREQ_SPAN});
			end else begin
				f_adj = $signed({2'b00, FREQ_HIGH});
			end
		end
	end

	// A tone slide stops once it reaches or passes its target.
	assign pitch_new = {o_adj, f_adj[9:0]};
	assign pitch_tgt = {cur.toctave, cur.tfnum};
	assign reached = step_sel[7] ? (pitch_new <= pitch_tgt) : (pitch_new >= pitch_tgt);

	// Slide direction for a new target.
	assign spd_new   = (slide_speed_in != 7'd0) ? slide_speed_in : cur.speed;
	assign pitch_cur = {cur.octave, cur.fnum};
	assign pitch_set = {octave_in, fnum_in};
	always_comb begin
		if (spd_new == 7'd0 || pitch_cur == pitch_set) begin
			dir_new = 8'd0;
		end else if (pitch_cur > pitch_set) begin
			dir_new = 8'd0 - {1'b0, spd_new};
		end else begin
			dir_new = {1'b0, spd_new};
		end
	end

	// Next channel state, whether the register bytes go out, and the bytes themselves.
	always_comb begin
		nxt = cur;
		res.emit = 1'b0;
		case (opcode)
			OP_SET_NOTE: begin
				nxt.fnum   = fnum_in;
				nxt.octave = octave_in;
				nxt.key_on = key_on_in;
				res.emit   = 1'b1;
			end
			OP_SET_TARGET: begin
				nxt.tfnum   = fnum_in;
				nxt.toctave = octave_in;
				nxt.speed   = spd_new;
				nxt.dir     = dir_new;
			end
			OP_PORTA: begin
				nxt.fnum   = f_adj[9:0];
				nxt.octave = o_adj;
				res.emit   = 1'b1;
			end
			OP_TONE: begin
				if (cur.dir != 8'd0) begin
					if (reached) begin
						nxt.fnum   = cur.tfnum;
						nxt.octave = cur.toctave;
					end else begin
						nxt.fnum   = f_adj[9:0];
						nxt.octave = o_adj;
					end
					res.emit = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase

		// Register bytes from the updated state.
		res.freq_byte  = nxt.fnum[7:0];
		res.block_byte = {3'b000, nxt.octave, nxt.fnum[9:8]}
			| (nxt.key_on ? KEY_ON_MASK : 8'h00);
	end

endmodule

>>> hw/rtl/fmps_out_buf.sv
`timescale 1ns / 1ps

module fmps_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [3:0]      load_chan,
	input  fmps_pkg::emit_t load_res,
	output logic            can_load,
	output logic            valid,
	input  logic            stall,
	output logic [3:0]      out_chan,
	output logic            reg_kind,
	output logic [7:0]      reg_data,
	output logic            last_write
);
	import fmps_pkg::*;

	logic       valid_q;
	logic       second_q;
	logic [3:0] chan_q;
	logic [7:0] freq_q;
	logic [7:0] block_q;
	logic       out_take;

	assign out_take = valid_q && !stall;

	// A new pair fits when the buffer is empty or its last byte leaves now.
	assign can_load = !valid_q || (second_q && !stall);

	// Control: walk through the two bytes of a pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q  <= 1'b1;
			second_q <= 1'b0;
		end else if (out_take) begin
			if (second_q) begin
				valid_q  <= 1'b0;
				second_q <= 1'b0;
			end else begin
				second_q <= 1'b1;
			end
		end
	end

	// Payload of the pending pair.
	always_ff @(posedge clk) begin
		if (load) begin
			chan_q  <= load_chan;
			freq_q  <= load_res.freq_byte;
			block_q <= load_res.block_byte;
		end
	end

	assign valid      = valid_q;
	assign out_chan   = chan_q;
	assign reg_kind   = second_q ? REG_BLOCK : REG_FREQ_LOW;
	assign reg_data   = second_q ? block_q : freq_q;
	assign last_write = second_q;

endmodule

>>> hw/rtl/fm_channel_pitch_slide_unit.sv
`timescale 1ns / 1ps
// An accepted item is registered in the item stage, then its register bytes load into the output
// buffer, which sends the frequency-low byte and then the block/key byte, holding each while stalled.
// Items that write registers are paced by the single output port that sends both bytes in turn; a new
// pair can load as the last byte of the previous one leaves, and items that write nothing do not wait.
// Reset: all channel state clears to zero and both stages empty.
module fm_channel_pitch_slide_unit #(
	parameter int NUM_CHANNELS = fmps_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  chan,
	input  logic [9:0]  fnum_in,
	input  logic [2:0]  octave_in,
	input  logic        key_on_in,
	input  logic [6:0]  slide_speed_in,
	input  logic signed [7:0] step_amount,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  out_chan,
	output logic        reg_kind,
	output logic [7:0]  reg_data,
	output logic        last_write
);
	import fmps_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic              valid_s1;
	opcode_t           opcode_s1;
	logic [3:0]        chan_s1;
	logic [9:0]        fnum_s1;
	logic [2:0]        octave_s1;
	logic              key_on_s1;
	logic [6:0]        speed_s1;
	logic signed [7:0] step_s1;

	logic              in_range;
	logic              can_load;
	logic              adv_s1;
	logic              in_take;
	chan_state_t       cur_st;
	chan_state_t       nxt_st;
	emit_t             res;

	// The item stage moves on when its item writes no pair, or when the output can take its pair.
	assign in_range = 6'(chan_s1) < 6'(NUM_CHANNELS);
	assign adv_s1   = valid_s1 && (!(in_range && res.emit) || can_load);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	// Item stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Item stage payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1 <= opcode_t'(opcode);
			chan_s1   <= chan;
			fnum_s1   <= fnum_in;
			octave_s1 <= octave_in;
			key_on_s1 <= key_on_in;
			speed_s1  <= slide_speed_in;
			step_s1   <= step_amount;
		end
	end

	fmps_chan_state #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.IDX_W       (IDX_W)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (IDX_W'(chan_s1)),
		.wr_en  (adv_s1 && in_range),
		.wr_data(nxt_st),
		.rd_data(cur_st)
	);

	fmps_slide_core u_core (
		.opcode        (opcode_s1),
		.fnum_in       (fnum_s1),
		.octave_in     (octave_s1),
		.key_on_in     (key_on_s1),
		.slide_speed_in(speed_s1),
		.step_amount   (step_s1),
		.cur           (cur_st),
		.nxt           (nxt_st),
		.res           (res)
	);

	fmps_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv_s1 && in_range && res.emit),
		.load_chan (chan_s1),
		.load_res  (res),
		.can_load  (can_load),
		.valid     (out_valid),
		.stall     (out_stall),
		.out_chan  (out_chan),
		.reg_kind  (reg_kind),
		.reg_data  (reg_data),
		.last_write(last_write)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import fmps_pkg::*;

	localparam int NCH        = NUM_CHANNELS_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int RAND_ITEMS = 2000;
	localparam int MAX_PRINTS = 40;

	// One register write as it leaves the block.
	typedef struct {
		logic [3:0] ch;
		logic       kind;
		logic [7:0] data;
		logic       last;
	} reg_write_t;

	// Channel state mirror plus the queue of register writes still owed by the block.
	class reg_write_board;
		chan_state_t chans[NCH];
		reg_write_t  pending_writes[$];
		int          errors;
		int          checked;

		function new();
			foreach (chans[i]) chans[i] = '0;
			errors  = 0;
			checked = 0;
		endfunction

		function int pending();
			return pending_writes.size();
		endfunction

		// Queue the frequency-low byte, then the block/key byte, of one channel.
		function void push_pair(int ch);
			reg_write_t w;
			w.ch   = 4'(ch);
			w.kind = REG_FREQ_LOW;
			w.data = chans[ch].fnum[7:0];
			w.last = 1'b0;
			pending_writes.push_back(w);
			w.kind = REG_BLOCK;
			w.data = {6'b0, chans[ch].fnum[9:8]} | ({5'b0, chans[ch].octave} << 2) |
				(chans[ch].key_on ? KEY_ON_MASK : 8'h00);
			w.last = 1'b1;
			pending_writes.push_back(w);
		endfunction

		// Move the pitch by a signed step with octave wrap and clamp; a tone slide
		// also snaps to its target once it reaches or passes it.
		function void apply_slide(int ch, int st, bit tone);
			int f, oct, toct, tf;
			bit reached;
			f    = int'(chans[ch].fnum) + st;
			oct  = int'(chans[ch].octave);
			toct = int'(chans[ch].toctave);
			tf   = int'(chans[ch].tfnum);
			if (f < int'(FREQ_LOW)) begin
				if (oct > int'(OCT_MIN)) begin
					oct = oct - 1;
					f   = f + int'(FREQ_SPAN);
				end else begin
					f = int'(FREQ_LOW);
				end
			end else if (f > int'(FREQ_HIGH)) begin
				if (oct < int'(OCT_MAX)) begin
					oct = oct + 1;
					f   = f - int'(FREQ_SPAN);
				end else begin
					f = int'(FREQ_HIGH);
				end
			end
			if (tone) begin
				if (st >= 0)
					reached = (oct > toct) || (oct == toct && f >= tf);
				else
					reached = (oct < toct) || (oct == toct && f <= tf);
				if (reached) begin
					f   = tf;
					oct = toct;
				end
			end
			chans[ch].fnum   = f[9:0];
			chans[ch].octave = oct[2:0];
		endfunction

		// Update the mirror for one accepted input transaction.
		function void note_input(opcode_t op, logic [3:0] ch, logic [9:0] fn, logic [2:0] oc,
				logic key, logic [6:0] spd, logic signed [7:0] st);
			int c, d;
			c = int'(ch);
			if (c >= NCH)
				return;
			case (op)
				OP_SET_NOTE: begin
					chans[c].fnum   = fn;
					chans[c].octave = oc;
					chans[c].key_on = key;
					push_pair(c);
				end
				OP_SET_TARGET: begin
					chans[c].tfnum   = fn;
					chans[c].toctave = oc;
					if (spd != 0)
						chans[c].speed = spd;
					d = 0;
					if (chans[c].speed != 0) begin
						d = int'(chans[c].speed);
						if (chans[c].octave > oc)
							d = -d;
						else if (chans[c].octave == oc) begin
							if (chans[c].fnum > fn)
								d = -d;
							else if (chans[c].fnum == fn)
								d = 0;
						end
					end
					chans[c].dir = d[7:0];
				end
				OP_PORTA: begin
					apply_slide(c, int'(st), 1'b0);
					push_pair(c);
				end
				default: begin
					d = int'($signed(chans[c].dir));
					if (d != 0) begin
						apply_slide(c, d, 1'b1);
						push_pair(c);
					end
				end
			endcase
		endfunction

		// Compare one output transaction with the oldest queued write.
		function void check_result(logic [3:0] ch, logic kind, logic [7:0] data, logic last);
			reg_write_t w;
			if (pending_writes.size() == 0) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: unexpected write chan=%0d kind=%0d data=%02h last=%0d",
						$time, ch, kind, data, last);
				return;
			end
			w = pending_writes.pop_front();
			checked++;
			if (ch !== w.ch) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: out_chan expected %0d actual %0d", $time, w.ch, ch);
			end
			if (kind !== w.kind) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: reg_kind expected %0d actual %0d", $time, w.kind, kind);
			end
			if (data !== w.data) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: reg_data expected %02h actual %02h", $time, w.data, data);
			end
			if (last !== w.last) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: last_write expected %0d actual %0d", $time, w.last, last);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        opcode;
	logic [3:0]        chan;
	logic [9:0]        fnum_in;
	logic [2:0]        octave_in;
	logic              key_on_in;
	logic [6:0]        slide_speed_in;
	logic signed [7:0] step_amount;
	logic              out_valid;
	logic              out_stall;
	logic [3:0]        out_chan;
	logic              reg_kind;
	logic [7:0]        reg_data;
	logic              last_write;

	reg_write_board board;
	int             src_idle_pct;
	int             sink_stall_pct;
	int             sent_valid;
	int             n_inputs = 0;
	int             n_writes = 0;
	int             idle_cycles = 0;

	fm_channel_pitch_slide_unit #(
		.NUM_CHANNELS(NCH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.chan(chan),
		.fnum_in(fnum_in),
		.octave_in(octave_in),
		.key_on_in(key_on_in),
		.slide_speed_in(slide_speed_in),
		.step_amount(step_amount),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_chan(out_chan),
		.reg_kind(reg_kind),
		.reg_data(reg_data),
		.last_write(last_write)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver stalls at random according to the current phase.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	// Check writes, record accepted inputs and watch for a stuck handshake.
	always @(posedge clk) begin
		if (arst_n && board != null) begin
			if (out_valid && !out_stall) begin
				board.check_result(out_chan, reg_kind, reg_data, last_write);
				n_writes++;
			end
			if (in_valid && !in_stall) begin
				board.note_input(opcode_t'(opcode), chan, fnum_in, octave_in, key_on_in,
					slide_speed_in, step_amount);
				n_inputs++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Select the idling pattern of both sides.
	task automatic set_phase(int p);
		case (p)
			0: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct   = 69;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct   = 0;
				sink_stall_pct = 69;
			end
			default: begin
				src_idle_pct   = 7;
				sink_stall_pct = 7;
			end
		endcase
	endtask

	// Present one input transaction after a random gap and hold it until accepted.
	task automatic send_item(opcode_t op, logic [3:0] ch, logic [9:0] fn, logic [2:0] oc,
			logic key, logic [6:0] spd, logic signed [7:0] st);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		opcode         <= op;
		chan           <= ch;
		fnum_in        <= fn;
		octave_in      <= oc;
		key_on_in      <= key;
		slide_speed_in <= spd;
		step_amount    <= st;
		do
			@(posedge clk);
		while (in_stall);
		if (int'(ch) < NCH)
			sent_valid++;
	endtask

	function automatic logic [3:0] pick_chan();
		return 4'($urandom_range(0, NCH - 1));
	endfunction

	// A frequency number inside one octave window, edges included.
	function automatic logic [9:0] pick_win_fnum();
		return 10'($urandom_range(int'(FREQ_LOW), int'(FREQ_HIGH)));
	endfunction

	initial begin
		logic [3:0] ch;
		logic [2:0] oc, toc;
		logic [6:0] spd;
		int         r, n, k;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		opcode         = OP_SET_NOTE;
		chan           = '0;
		fnum_in        = '0;
		octave_in      = '0;
		key_on_in      = 1'b0;
		slide_speed_in = '0;
		step_amount    = '0;
		sent_valid     = 0;
		set_phase(0);
		board = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: field extremes, clamps, wraps and the cases that write nothing.
		send_item(OP_SET_NOTE, 4'd0, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);
		send_item(OP_PORTA, 4'd0, 10'd0, 3'd0, 1'b0, 7'd0, -8'sd128);
		send_item(OP_SET_NOTE, 4'd8, 10'd1023, 3'd7, 1'b1, 7'd127, 8'sd127);
		send_item(OP_PORTA, 4'd8, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd127);
		send_item(OP_SET_NOTE, 4'd1, 10'h100, 3'd3, 1'b1, 7'd0, 8'sd0);
		send_item(OP_PORTA, 4'd1, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);
		send_item(OP_SET_NOTE, 4'd2, FREQ_HIGH, 3'd3, 1'b0, 7'd0, 8'sd0);
		send_item(OP_PORTA, 4'd2, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd1);
		send_item(OP_TONE, 4'd3, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);
		send_item(OP_SET_TARGET, 4'd3, 10'h200, 3'd4, 1'b0, 7'd0, 8'sd0);
		send_item(OP_TONE, 4'd3, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);
		send_item(OP_SET_NOTE, 4'd4, 10'h180, 3'd2, 1'b1, 7'd0, 8'sd0);
		send_item(OP_SET_TARGET, 4'd4, 10'h200, 3'd2, 1'b0, 7'd127, 8'sd0);
		send_item(OP_TONE, 4'd4, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);
		send_item(OP_TONE, 4'd4, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);
		send_item(OP_SET_TARGET, 4'd4, FREQ_LOW, 3'd1, 1'b0, 7'd0, 8'sd0);
		send_item(OP_TONE, 4'd4, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);
		send_item(OP_TONE, 4'd4, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);
		send_item(OP_SET_TARGET, 4'd5, 10'd0, 3'd0, 1'b0, 7'd5, 8'sd0);
		send_item(OP_TONE, 4'd5, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);
		send_item(OP_SET_NOTE, 4'd9, 10'h155, 3'd5, 1'b1, 7'd1, 8'sd1);
		send_item(OP_PORTA, 4'd15, 10'h3FF, 3'd7, 1'b1, 7'd127, -8'sd1);
		send_item(OP_SET_TARGET, 4'd6, 10'd1023, 3'd7, 1'b1, 7'd1, 8'sd0);
		send_item(OP_TONE, 4'd6, 10'd0, 3'd0, 1'b0, 7'd0, 8'sd0);

		// Random part: mostly complete slide sequences, the rest loose items.
		sent_valid = 0;
		while (sent_valid < RAND_ITEMS) begin
			set_phase((sent_valid / 250) % 4);
			r = $urandom_range(0, 99);
			if (r < 55) begin
				// Note, slide target near it, then a run of tone-slide ticks.
				ch  = pick_chan();
				oc  = 3'($urandom_range(0, 7));
				toc = oc;
				k   = $urandom_range(0, 3);
				if (k == 0 && oc < OCT_MAX)
					toc = oc + 3'd1;
				else if (k == 1 && oc > OCT_MIN)
					toc = oc - 3'd1;
				spd = ($urandom_range(0, 9) == 0) ? 7'd0 :
					($urandom_range(0, 3) == 0) ? 7'($urandom_range(1, 127)) :
					7'($urandom_range(1, 40));
				send_item(OP_SET_NOTE, ch, pick_win_fnum(), oc, 1'($urandom), 7'($urandom),
					8'($urandom));
				send_item(OP_SET_TARGET, ch, pick_win_fnum(), toc, 1'($urandom), spd,
					8'($urandom));
				n = $urandom_range(1, 12);
				repeat (n)
					send_item(OP_TONE, ch, 10'($urandom), 3'($urandom), 1'($urandom),
						7'($urandom), 8'($urandom));
			end else if (r < 80) begin
				// Portamento run, sometimes from a fresh note.
				ch = pick_chan();
				if ($urandom_range(0, 1) == 1)
					send_item(OP_SET_NOTE, ch, pick_win_fnum(), 3'($urandom), 1'($urandom),
						7'($urandom), 8'($urandom));
				n = $urandom_range(1, 8);
				repeat (n)
					send_item(OP_PORTA, ch, 10'($urandom), 3'($urandom), 1'($urandom),
						7'($urandom), 8'($urandom));
			end else begin
				// Fully random transaction, stray channels included.
				send_item(opcode_t'($urandom_range(0, 3)), 4'($urandom), 10'($urandom),
					3'($urandom), 1'($urandom), 7'($urandom), 8'($urandom));
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain the outstanding writes, then watch a little longer for strays.
		while (board.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d input transactions and %0d register writes, %0d checked.",
			n_inputs, n_writes, board.checked);
		$display("Idling phases: none, sender gaps, receiver stalls, both; %0d errors.",
			board.errors);
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/fmps_pkg.sv
hw/rtl/fmps_chan_state.sv
hw/rtl/fmps_slide_core.sv
hw/rtl/fmps_out_buf.sv
hw/rtl/fm_channel_pitch_slide_unit.sv
tb/tb_top.sv
